/* src/sspq_pkg.sv */
// ----------------------------------------------------------------------------
// sspq_pkg
// shared opcodes, cell commands and field widths for the sorted queue
// ----------------------------------------------------------------------------
package sspq_pkg;

  localparam int OPCODE_BITS = 2;
  localparam int COUNT_BITS  = 5;

  typedef enum logic [OPCODE_BITS-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_POP    = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  // command broadcast to every cell of the row
  typedef enum logic [2:0] {
    CMD_HOLD    = 3'd0,
    CMD_INSERT  = 3'd1,
    CMD_POP     = 3'd2,
    CMD_COMPACT = 3'd3,
    CMD_CLEAR   = 3'd4
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
  } cell_ctrl_t;

endpackage

/* src/sspq_cell.sv */
// ----------------------------------------------------------------------------
// sspq_cell
// one slot of the sorted row: holds an entry and trades it with its neighbors
// ----------------------------------------------------------------------------
module sspq_cell #(
  parameter int PAYLOAD_BITS  = 16,
  parameter int PRIORITY_BITS = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  sspq_pkg::cell_ctrl_t     ctrl,
  input  logic [PRIORITY_BITS-1:0] key,
  input  logic [PAYLOAD_BITS-1:0]  new_payload,
  // left neighbor (toward the head)
  input  logic                     left_ge,
  input  logic                     left_valid,
  input  logic [PAYLOAD_BITS-1:0]  left_payload,
  input  logic [PRIORITY_BITS-1:0] left_priority,
  // right neighbor (toward the tail)
  input  logic                     right_valid,
  input  logic [PAYLOAD_BITS-1:0]  right_payload,
  input  logic [PRIORITY_BITS-1:0] right_priority,
  output logic                     valid,
  output logic [PAYLOAD_BITS-1:0]  payload,
  output logic [PRIORITY_BITS-1:0] priority_q,
  output logic                     ge,
  output logic                     match,
  output logic                     valid_next,
  output logic [PAYLOAD_BITS-1:0]  payload_next,
  output logic [PRIORITY_BITS-1:0] priority_next
);

  logic le;

  assign ge    = valid && (priority_q >= key);
  assign le    = valid && (priority_q <= key);
  assign match = valid && (priority_q == key);

  always_comb begin
    valid_next    = valid;
    payload_next  = payload;
    priority_next = priority_q;
    case (ctrl.cmd)
      sspq_pkg::CMD_INSERT: begin
        if (!ge) begin
          if (left_ge) begin
            // new entry lands right after the last entry of equal or higher priority
            valid_next    = 1'b1;
            payload_next  = new_payload;
            priority_next = key;
          end else begin
            valid_next    = left_valid;
            payload_next  = left_payload;
            priority_next = left_priority;
          end
        end
      end
      sspq_pkg::CMD_POP: begin
        valid_next    = right_valid;
        payload_next  = right_payload;
        priority_next = right_priority;
      end
      sspq_pkg::CMD_COMPACT: begin
        // the matching run sits just ahead of all lower priorities
        if (le) begin
          valid_next    = right_valid;
          payload_next  = right_payload;
          priority_next = right_priority;
        end
      end
      sspq_pkg::CMD_CLEAR: valid_next = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    payload    <= payload_next;
    priority_q <= priority_next;
  end

endmodule

/* src/stable_sorted_priority_queue_core.sv */
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue_core
// sorted-list priority queue built from a row of shifting cells
// ----------------------------------------------------------------------------
// channel  dir  tdata fields (lsb first)                          transaction
// s_*      in   opcode, payload_in, priority_in                   one operation
// m_*      out  head_valid, head_payload, head_priority,          one result
//               entry_count, removed_count, overflow
//
// insert, pop and clear are accepted in IDLE and update the row in EXEC
// remove-by-priority compacts the row in EXEC until no entry matches; the row drops
// one matching entry per cycle
// rst is synchronous; it empties the row, no clearing pass is needed
// a finished result waits in the output register; the next operation is
// accepted meanwhile and stalls in EXEC before it finishes until that result is taken
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue_core #(
  parameter int DEPTH         = 16,
  parameter int PAYLOAD_BITS  = 16,
  parameter int PRIORITY_BITS = 8,
  localparam int IN_BYTES  =
    (sspq_pkg::OPCODE_BITS + PAYLOAD_BITS + PRIORITY_BITS + 7) / 8,
  localparam int OUT_BYTES =
    (2 + PAYLOAD_BITS + PRIORITY_BITS + 2 * sspq_pkg::COUNT_BITS + 7) / 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // opcode, payload_in, priority_in, zero fill
  input  logic [IN_BYTES*8-1:0]  s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  // head_valid, head_payload, head_priority, entry_count, removed_count,
  // overflow, zero fill
  output logic [OUT_BYTES*8-1:0] m_tdata
);

  localparam int CB        = sspq_pkg::COUNT_BITS;
  localparam int OB        = sspq_pkg::OPCODE_BITS;
  localparam int IN_BITS   = OB + PAYLOAD_BITS + PRIORITY_BITS;
  localparam int OUT_BITS  = 2 + PAYLOAD_BITS + PRIORITY_BITS + 2 * CB;
  localparam int CW        = $clog2(DEPTH + 1);
  localparam int CX        = CW + CB;

  typedef enum logic {IDLE, EXEC} state_t;

  state_t                   state;
  sspq_pkg::opcode_t        op;
  logic [PAYLOAD_BITS-1:0]  op_payload;
  logic [PRIORITY_BITS-1:0] op_priority;
  logic [CW-1:0]            count;
  logic [CW-1:0]            removed;

  logic [CW-1:0]            count_next;
  logic [CW-1:0]            removed_next;
  logic                     ovf;
  logic                     finish;
  logic                     out_free;
  logic                     any_match;
  logic [CX-1:0]            count_ext;
  logic [CX-1:0]            removed_ext;
  logic [OUT_BITS-1:0]      result;
  sspq_pkg::cell_ctrl_t     ctrl;

  // row signals, index 0 is the head
  logic [DEPTH-1:0]         c_valid;
  logic [PAYLOAD_BITS-1:0]  c_payload  [DEPTH];
  logic [PRIORITY_BITS-1:0] c_priority [DEPTH];
  logic [DEPTH-1:0]         c_ge;
  logic [DEPTH-1:0]         c_match;
  logic [DEPTH-1:0]         n_valid;
  logic [PAYLOAD_BITS-1:0]  n_payload  [DEPTH];
  logic [PRIORITY_BITS-1:0] n_priority [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                     l_ge;
    logic                     l_valid;
    logic [PAYLOAD_BITS-1:0]  l_payload;
    logic [PRIORITY_BITS-1:0] l_priority;
    logic                     r_valid;
    logic [PAYLOAD_BITS-1:0]  r_payload;
    logic [PRIORITY_BITS-1:0] r_priority;

    if (i == 0) begin : g_head
      // head cell sees an endless run of equal or higher priorities on its left
      assign l_ge       = 1'b1;
      assign l_valid    = 1'b0;
      assign l_payload  = '0;
      assign l_priority = '0;
    end else begin : g_mid
      assign l_ge       = c_ge[i-1];
      assign l_valid    = c_valid[i-1];
      assign l_payload  = c_payload[i-1];
      assign l_priority = c_priority[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_valid    = 1'b0;
      assign r_payload  = '0;
      assign r_priority = '0;
    end else begin : g_body
      assign r_valid    = c_valid[i+1];
      assign r_payload  = c_payload[i+1];
      assign r_priority = c_priority[i+1];
    end

    sspq_cell #(
      .PAYLOAD_BITS  (PAYLOAD_BITS),
      .PRIORITY_BITS (PRIORITY_BITS)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .ctrl           (ctrl),
      .key            (op_priority),
      .new_payload    (op_payload),
      .left_ge        (l_ge),
      .left_valid     (l_valid),
      .left_payload   (l_payload),
      .left_priority  (l_priority),
      .right_valid    (r_valid),
      .right_payload  (r_payload),
      .right_priority (r_priority),
      .valid          (c_valid[i]),
      .payload        (c_payload[i]),
      .priority_q     (c_priority[i]),
      .ge             (c_ge[i]),
      .match          (c_match[i]),
      .valid_next     (n_valid[i]),
      .payload_next   (n_payload[i]),
      .priority_next  (n_priority[i])
    );
  end

  assign s_tready  = (state == IDLE);
  assign out_free  = !m_tvalid || m_tready;
  assign any_match = |c_match;

  // per-cycle control of the row while an operation is in flight
  always_comb begin
    ctrl.cmd     = sspq_pkg::CMD_HOLD;
    finish       = 1'b0;
    ovf          = 1'b0;
    count_next   = count;
    removed_next = removed;
    if (state == EXEC) begin
      unique case (op)
        sspq_pkg::OP_INSERT: begin
          if (out_free) begin
            finish = 1'b1;
            if (count == CW'(DEPTH)) begin
              ovf = 1'b1;     // full: entry dropped
            end else begin
              ctrl.cmd   = sspq_pkg::CMD_INSERT;
              count_next = count + 1'b1;
            end
          end
        end
        sspq_pkg::OP_REMOVE: begin
          if (any_match) begin
            // drop the first matching entry, the tail closes up by one
            ctrl.cmd     = sspq_pkg::CMD_COMPACT;
            count_next   = count - 1'b1;
            removed_next = removed + 1'b1;
          end else begin
            finish = out_free;
          end
        end
        sspq_pkg::OP_POP: begin
          if (out_free) begin
            finish = 1'b1;
            if (count != '0) begin
              ctrl.cmd     = sspq_pkg::CMD_POP;
              count_next   = count - 1'b1;
              removed_next = CW'(1);
            end
          end
        end
        sspq_pkg::OP_CLEAR: begin
          if (out_free) begin
            finish       = 1'b1;
            ctrl.cmd     = sspq_pkg::CMD_CLEAR;
            count_next   = '0;
            removed_next = count;
          end
        end
        default: ;
      endcase
    end
  end

  // counts wrap to the field width when the row is deeper than the field
  assign count_ext   = CX'(count_next);
  assign removed_ext = CX'(removed_next);

  always_comb begin
    result = '0;
    if (count_next != '0) begin
      result[0]                                = 1'b1;
      result[PAYLOAD_BITS:1]                   = n_payload[0];
      result[PAYLOAD_BITS+PRIORITY_BITS:PAYLOAD_BITS+1] = n_priority[0];
    end
    result[PAYLOAD_BITS+PRIORITY_BITS+CB:PAYLOAD_BITS+PRIORITY_BITS+1] =
      count_ext[CB-1:0];
    result[PAYLOAD_BITS+PRIORITY_BITS+2*CB:PAYLOAD_BITS+PRIORITY_BITS+CB+1] =
      removed_ext[CB-1:0];
    result[OUT_BITS-1] = ovf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      count    <= '0;
      removed  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (s_tvalid) begin
            state   <= EXEC;
            removed <= '0;
          end
        end
        EXEC: begin
          count   <= count_next;
          removed <= removed_next;
          if (finish) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
    // operation fields and result data need no reset
    if (s_tvalid && s_tready) begin
      op          <= sspq_pkg::opcode_t'(s_tdata[OB-1:0]);
      op_payload  <= s_tdata[OB+PAYLOAD_BITS-1:OB];
      op_priority <= s_tdata[IN_BITS-1:OB+PAYLOAD_BITS];
    end
    if (finish) begin
      m_tdata <= (OUT_BYTES*8)'(result);
    end
  end

  // held count always equals the number of occupied cells
  assert property (@(posedge clk) disable iff (rst)
    $countones(c_valid) == int'(count))
    else $error("entry count disagrees with occupied cells");

  // occupied cells form one run starting at the head
  assert property (@(posedge clk) disable iff (rst)
    (DEPTH'(c_valid + 1'b1) & c_valid) == '0)
    else $error("gap in the cell row");

  // an accepted transaction starts with a fresh removed count
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == EXEC) && (removed == '0))
    else $error("operation did not start cleanly");

  // a new result is only loaded once the previous one has left
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
    else $error("pending result overwritten");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the stable sorted priority queue core
// ----------------------------------------------------------------------------
// every operation accepted on the s_* stream is run through a behavioral copy
// of the queue and the status it should report is queued; every transaction
// on the m_* stream is compared field by field with the oldest pending report.
// directed tests cover the empty queue, fifo order among equal priorities,
// removal and a full queue; random phases follow with and without idling.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int DEPTH         = 16;
  localparam int PAYLOAD_BITS  = 16;
  localparam int PRIORITY_BITS = 8;
  localparam int COUNT_BITS    = sspq_pkg::COUNT_BITS;
  localparam int IN_WIDTH      = 32;   // 26 bits of fields, padded to 4 bytes
  localparam int OUT_WIDTH     = 40;   // 36 bits of fields, padded to 5 bytes
  localparam int QUIET_LIMIT   = 1000; // cycles without any transaction
  localparam int DRAIN_CYCLES  = 40;   // covers a 16-entry removal plus margin

  // status report, declared msb first so it maps straight onto m_tdata
  typedef struct packed {
    logic                     overflow;
    logic [COUNT_BITS-1:0]    removed_count;
    logic [COUNT_BITS-1:0]    entry_count;
    logic [PRIORITY_BITS-1:0] head_priority;
    logic [PAYLOAD_BITS-1:0]  head_payload;
    logic                     head_valid;
  } report_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  // opcode, payload_in, priority_in, zero fill
  logic [IN_WIDTH-1:0]  s_tdata;
  logic                 m_tvalid;
  logic                 m_tready;
  // head_valid, head_payload, head_priority, entry_count, removed_count,
  // overflow, zero fill
  logic [OUT_WIDTH-1:0] m_tdata;

  // behavioral copy of the queue, head at index 0
  logic [PAYLOAD_BITS-1:0]  model_payload [DEPTH];
  logic [PRIORITY_BITS-1:0] model_prio    [DEPTH];
  int                       model_count;

  report_t predicted_reports [$];

  int error_count;
  int quiet_cycles;
  int op_tally [4];
  int overflow_hits;
  int largest_removal;
  bit tx_idle_on;
  bit rx_stall_on;

  stable_sorted_priority_queue_core #(
    .DEPTH        (DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .PRIORITY_BITS(PRIORITY_BITS)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // apply one operation to the behavioral queue and return the status it
  // should produce
  function automatic report_t predict_report(sspq_pkg::opcode_t op,
                                             logic [PAYLOAD_BITS-1:0] pay,
                                             logic [PRIORITY_BITS-1:0] pri);
    report_t rep;
    int pos;
    int wr;
    int i;
    rep = '0;
    case (op)
      sspq_pkg::OP_INSERT: begin
        if (model_count >= DEPTH) begin
          // full: entry dropped, queue untouched
          rep.overflow = 1'b1;
        end else begin
          // stable: goes behind every entry of equal or higher priority
          pos = 0;
          while (pos < model_count && model_prio[pos] >= pri) pos++;
          for (i = model_count; i > pos; i--) begin
            model_payload[i] = model_payload[i-1];
            model_prio[i]    = model_prio[i-1];
          end
          model_payload[pos] = pay;
          model_prio[pos]    = pri;
          model_count++;
        end
      end
      sspq_pkg::OP_REMOVE: begin
        wr = 0;
        for (i = 0; i < model_count; i++) begin
          if (model_prio[i] != pri) begin
            model_payload[wr] = model_payload[i];
            model_prio[wr]    = model_prio[i];
            wr++;
          end
        end
        rep.removed_count = COUNT_BITS'(model_count - wr);
        model_count       = wr;
      end
      sspq_pkg::OP_POP: begin
        if (model_count > 0) begin
          for (i = 1; i < model_count; i++) begin
            model_payload[i-1] = model_payload[i];
            model_prio[i-1]    = model_prio[i];
          end
          model_count--;
          rep.removed_count = COUNT_BITS'(1);
        end
      end
      default: begin
        rep.removed_count = COUNT_BITS'(model_count);
        model_count       = 0;
      end
    endcase
    if (model_count > 0) begin
      rep.head_valid    = 1'b1;
      rep.head_payload  = model_payload[0];
      rep.head_priority = model_prio[0];
    end
    rep.entry_count = COUNT_BITS'(model_count);
    return rep;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  // checks each result transaction, then predicts for each accepted operation;
  // a result never belongs to the operation accepted at the same edge
  always @(posedge clk) begin : scoreboard
    report_t got;
    report_t want;
    report_t fresh;
    sspq_pkg::opcode_t op;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = report_t'(m_tdata[$bits(report_t)-1:0]);
        if (predicted_reports.size() == 0) begin
          $error("unexpected result transaction 0x%0h", got);
          error_count++;
        end else begin
          want = predicted_reports.pop_front();
          check_field("head_valid",    32'(want.head_valid),    32'(got.head_valid));
          check_field("head_payload",  32'(want.head_payload),  32'(got.head_payload));
          check_field("head_priority", 32'(want.head_priority), 32'(got.head_priority));
          check_field("entry_count",   32'(want.entry_count),   32'(got.entry_count));
          check_field("removed_count", 32'(want.removed_count), 32'(got.removed_count));
          check_field("overflow",      32'(want.overflow),      32'(got.overflow));
        end
      end
      if (s_tvalid && s_tready) begin
        op    = sspq_pkg::opcode_t'(s_tdata[1:0]);
        fresh = predict_report(op, s_tdata[17:2], s_tdata[25:18]);
        predicted_reports.push_back(fresh);
        op_tally[op]++;
        if (fresh.overflow) overflow_hits++;
        if (fresh.removed_count > largest_removal) largest_removal = fresh.removed_count;
      end
    end
  end

  // ends the run if the design stops moving transactions
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stall before each transaction when enabled
  initial begin : result_sink
    int stall;
    m_tready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      stall = rx_stall_on ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  // drives one operation and returns at the falling edge after its
  // transaction; tvalid stays high so a back-to-back send needs no toggle
  task automatic send_op(sspq_pkg::opcode_t op, logic [PAYLOAD_BITS-1:0] pay,
                         logic [PRIORITY_BITS-1:0] pri);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, pri, pay, op};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic wait_until_drained();
    s_tvalid <= 1'b0;
    while (predicted_reports.size() != 0) @(negedge clk);
  endtask

  task automatic test_empty_queue_ops();
    send_op(sspq_pkg::OP_POP,    16'h1234, 8'h00);
    send_op(sspq_pkg::OP_REMOVE, 16'h0000, 8'h42);
    send_op(sspq_pkg::OP_CLEAR,  16'hFFFF, 8'hFF);
  endtask

  // fifo among equal priorities, removal of absent and present priorities, pop and clear
  task automatic test_order_and_removal();
    send_op(sspq_pkg::OP_INSERT, 16'hFFFF, 8'hFF);
    send_op(sspq_pkg::OP_INSERT, 16'h0000, 8'h00);
    send_op(sspq_pkg::OP_INSERT, 16'h0001, 8'hFF);
    send_op(sspq_pkg::OP_INSERT, 16'h8000, 8'h80);
    send_op(sspq_pkg::OP_REMOVE, 16'h0000, 8'h33);
    send_op(sspq_pkg::OP_REMOVE, 16'hA5A5, 8'hFF);
    send_op(sspq_pkg::OP_POP,    16'h0000, 8'h00);
    send_op(sspq_pkg::OP_INSERT, 16'hABCD, 8'h01);
    send_op(sspq_pkg::OP_INSERT, 16'h5432, 8'hFE);
    send_op(sspq_pkg::OP_CLEAR,  16'h0000, 8'h00);
  endtask

  // fill with one priority, drop an urgent insert, then remove all sixteen
  task automatic test_full_queue();
    for (int i = 0; i < DEPTH; i++) begin
      send_op(sspq_pkg::OP_INSERT, PAYLOAD_BITS'(16'h1111 * i), 8'h5A);
    end
    send_op(sspq_pkg::OP_INSERT, 16'hFFFF, 8'hFF);
    send_op(sspq_pkg::OP_REMOVE, 16'h0000, 8'h5A);
  endtask

  // insert_pct steers fill level; removes mostly target a held priority
  task automatic test_random_ops(int n_ops, int insert_pct, bit tx_idle, bit rx_stall);
    sspq_pkg::opcode_t        op;
    logic [PAYLOAD_BITS-1:0]  pay;
    logic [PRIORITY_BITS-1:0] pri;
    int                       roll;
    tx_idle_on  = tx_idle;
    rx_stall_on = rx_stall;
    repeat (n_ops) begin
      roll = $urandom_range(0, 99);
      pay  = PAYLOAD_BITS'($urandom_range(0, 16'hFFFF));
      if (roll < insert_pct) begin
        op = sspq_pkg::OP_INSERT;
      end else begin
        roll = $urandom_range(0, 99);
        op   = (roll < 48) ? sspq_pkg::OP_POP :
               (roll < 96) ? sspq_pkg::OP_REMOVE : sspq_pkg::OP_CLEAR;
      end
      if (op == sspq_pkg::OP_REMOVE && model_count > 0 && $urandom_range(0, 9) < 7) begin
        pri = model_prio[$urandom_range(0, model_count - 1)];
      end else if ($urandom_range(0, 9) < 6) begin
        // small pool so equal priorities and multi-entry removals are common
        pri = PRIORITY_BITS'(8'h55 * $urandom_range(0, 3));
      end else begin
        pri = PRIORITY_BITS'($urandom_range(0, 255));
      end
      send_op(op, pay, pri);
    end
  endtask

  // sender holds off until the design has answered everything
  task automatic test_drain_pause();
    test_random_ops(60, 70, 1, 1);
    wait_until_drained();
    test_random_ops(60, 55, 1, 1);
  endtask

  initial begin
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    tx_idle_on  = 1'b1;
    rx_stall_on = 1'b1;
    model_count = 0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    test_empty_queue_ops();
    test_order_and_removal();
    test_full_queue();
    test_random_ops(220, 60, 1, 1);
    test_drain_pause();
    test_random_ops(200, 80, 0, 0);
    test_random_ops(150, 45, 1, 0);
    test_random_ops(110, 60, 0, 1);

    wait_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (predicted_reports.size() != 0) begin
      $error("%0d results never arrived", predicted_reports.size());
      error_count++;
    end

    $display("run covered %0d inserts, %0d removes, %0d pops and %0d clears",
             op_tally[sspq_pkg::OP_INSERT], op_tally[sspq_pkg::OP_REMOVE],
             op_tally[sspq_pkg::OP_POP], op_tally[sspq_pkg::OP_CLEAR]);
    $display("%0d inserts dropped on a full queue, largest single removal %0d entries",
             overflow_hits, largest_removal);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
